/* rtl/heightmap_triangle_height_sampler_top_macros.svh */
// Assertion macros for the heightmap triangle height sampler.
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLER_TOP_MACROS_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define HTSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HTSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define HTSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/htss_pkg.sv */
// Shared types and constants of the heightmap triangle height sampler.
`default_nettype none

package htss_pkg;

  // Fixed point and grid geometry.
  localparam int FRAC_BITS   = 8;
  localparam int SQUARE_LOG2 = 3;
  localparam int CELL_LOG2   = FRAC_BITS + SQUARE_LOG2;
  localparam int CELL_SIZE   = 1 << CELL_LOG2;
  localparam int ONE_FX      = 1 << FRAC_BITS;
  localparam int MAP_SIDE    = 128;
  localparam int TABLE_DEPTH = (MAP_SIDE + 1) * (MAP_SIDE + 1);

  // Field and datapath widths.
  localparam int TBL_AW     = $clog2(TABLE_DEPTH);
  localparam int ADDR_W     = TBL_AW + 1;
  localparam int H_W        = 24;
  localparam int COORD_IN_W = 20;
  localparam int COORD_W    = 18;
  localparam int IDX_IN_W   = 15;
  localparam int SQ_W       = COORD_W - CELL_LOG2;
  localparam int COEF_W     = CELL_LOG2 + 1;
  localparam int DIFF_W     = H_W + 1;
  localparam int PROD_W     = COEF_W + 1 + DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int Q_W        = SUM_W - CELL_LOG2;
  localparam int MW_W       = 8;
  localparam int STRIDE_W   = MW_W + 1;

  // Input and output word widths.
  localparam int IN_W  = 80;
  localparam int OUT_W = 24;

  // Configuration port.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_MAP_WIDTH = 2'd0;
  localparam logic [1:0] REG_MAX_X     = 2'd1;
  localparam logic [1:0] REG_MAX_Z     = 2'd2;

  localparam logic [MW_W-1:0]    MAP_WIDTH_RST = 8'd128;
  localparam logic [COORD_W-1:0] MAX_COORD_RST = 18'd261888;

  // Request kinds carried in tuser.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Request to the banked height table.
  typedef struct packed {
    logic                         rd_en;
    logic                         wr_en;
    logic [TBL_AW-1:0]            wr_addr;
    logic [H_W-1:0]               wr_data;
    logic [3:0][TBL_AW-1:0]       rd_addr;
  } tbl_req_t;

endpackage

`default_nettype wire

/* rtl/htss_table.sv */
// Height table: two identical copies, each with one write and two read ports.
`default_nettype none

module htss_table (
  input  wire logic                                   clk,
  input  wire htss_pkg::tbl_req_t                     req,
  output logic [3:0][htss_pkg::H_W-1:0]               rd_data
);

  logic [htss_pkg::H_W-1:0] mem_a [0:htss_pkg::TABLE_DEPTH-1];
  logic [htss_pkg::H_W-1:0] mem_b [0:htss_pkg::TABLE_DEPTH-1];

  // Every write goes to both copies so they always hold the same heights.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_a[req.wr_addr] <= req.wr_data;
      mem_b[req.wr_addr] <= req.wr_data;
    end
  end

  // Copy A serves the near row of the square, copy B the far row.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data[0] <= mem_a[req.rd_addr[0]];
      rd_data[1] <= mem_a[req.rd_addr[1]];
      rd_data[2] <= mem_b[req.rd_addr[2]];
      rd_data[3] <= mem_b[req.rd_addr[3]];
    end
  end

endmodule

`default_nettype wire

/* rtl/heightmap_triangle_height_sampler_top.sv */
// Top level of the heightmap triangle height sampler pipeline.
//
//   channel  direction  handshake               word
//   in_      slave      in_tvalid / in_tready   write or query request
//   out_     master     out_tvalid / out_tready interpolated height
//   cfg_     APB slave  psel, penable, pready   map width and clamp limits
//
// One request enters per cycle while in_tready is high; a query result
// passes through the eight register stages, with the height table read
// in stage four through two mirrored dual-read copies.
// Writes take effect in stage four and give no result word.
// Each stage advances when its successor is empty or advancing; a stalled
// output holds the whole chain without loss. Reset clears valid bits and
// resets configuration only; table contents are undefined until written.
`default_nettype none

module heightmap_triangle_height_sampler_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input stream.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata: entry_index[14:0], entry_height[38:15], query_x[58:39],
  // query_z[78:59], zero pad [79].
  input  wire logic [htss_pkg::IN_W-1:0]         in_tdata,
  // tuser: req_type.
  input  wire logic                              in_tuser,
  // Result stream.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // tdata: height_out[23:0].
  output logic [htss_pkg::OUT_W-1:0]             out_tdata,
  // Configuration port.
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [htss_pkg::CFG_AW-1:0]       cfg_paddr,
  input  wire logic [htss_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [htss_pkg::CFG_DW-1:0]            cfg_prdata,
  output logic                                   cfg_pready
);

`include "heightmap_triangle_height_sampler_top_macros.svh"

  localparam int H_W    = htss_pkg::H_W;
  localparam int AW     = htss_pkg::ADDR_W;
  localparam int TAW    = htss_pkg::TBL_AW;
  localparam int CW     = htss_pkg::COORD_W;
  localparam int CIW    = htss_pkg::COORD_IN_W;
  localparam int SQW    = htss_pkg::SQ_W;
  localparam int FW     = htss_pkg::CELL_LOG2;
  localparam int COEFW  = htss_pkg::COEF_W;
  localparam int DW     = htss_pkg::DIFF_W;
  localparam int PW     = htss_pkg::PROD_W;
  localparam int SW     = htss_pkg::SUM_W;
  localparam int QW     = htss_pkg::Q_W;
  localparam int IIW    = htss_pkg::IDX_IN_W;

  // ---------------------------------------------------------------------
  // Configuration registers.
  logic [htss_pkg::MW_W-1:0] map_width_r;
  logic [CW-1:0]             max_x_r;
  logic [CW-1:0]             max_z_r;
  logic [1:0]                cfg_idx;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r <= htss_pkg::MAP_WIDTH_RST;
      max_x_r     <= htss_pkg::MAX_COORD_RST;
      max_z_r     <= htss_pkg::MAX_COORD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        htss_pkg::REG_MAP_WIDTH: map_width_r <= cfg_pwdata[htss_pkg::MW_W-1:0];
        htss_pkg::REG_MAX_X:     max_x_r     <= cfg_pwdata[CW-1:0];
        htss_pkg::REG_MAX_Z:     max_z_r     <= cfg_pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      htss_pkg::REG_MAP_WIDTH: cfg_prdata = htss_pkg::CFG_DW'(map_width_r);
      htss_pkg::REG_MAX_X:     cfg_prdata = htss_pkg::CFG_DW'(max_x_r);
      htss_pkg::REG_MAX_Z:     cfg_prdata = htss_pkg::CFG_DW'(max_z_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its successor loads.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, out_valid_r;
  logic en1, en2, en3, en4, en5, en6, en7, en8;

  assign en8 = !out_valid_r || out_tready;
  assign en7 = !v7_r || en8;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_tready  = en1;
  assign out_tvalid = out_valid_r;

  // ---------------------------------------------------------------------
  // Stage 1: unpack, range-check the write index, clamp and split coords.
  logic signed [CIW-1:0] qx_in, qz_in;
  logic [CW-1:0]         cx_nxt, cz_nxt;
  logic                  wok1_nxt;

  logic                  q1_r, wok1_r;
  logic [TAW-1:0]        widx1_r;
  logic [H_W-1:0]        wh1_r;
  logic [SQW-1:0]        sx1_r, sz1_r;
  logic [FW-1:0]         rx1_r, rz1_r;

  localparam logic signed [CIW-1:0] ONE_S = CIW'(htss_pkg::ONE_FX);

  assign qx_in    = $signed(in_tdata[58:39]);
  assign qz_in    = $signed(in_tdata[78:59]);
  assign wok1_nxt = (in_tdata[IIW-1:0] < IIW'(htss_pkg::TABLE_DEPTH));

  // A coordinate below 1.0 snaps to 1.0 before the upper limit is checked.
  always_comb begin
    if (qx_in < ONE_S) begin
      cx_nxt = CW'(htss_pkg::ONE_FX);
    end else if (qx_in > $signed({2'b00, max_x_r})) begin
      cx_nxt = max_x_r;
    end else begin
      cx_nxt = qx_in[CW-1:0];
    end
    if (qz_in < ONE_S) begin
      cz_nxt = CW'(htss_pkg::ONE_FX);
    end else if (qz_in > $signed({2'b00, max_z_r})) begin
      cz_nxt = max_z_r;
    end else begin
      cz_nxt = qz_in[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      q1_r    <= (in_tuser == htss_pkg::REQ_QUERY);
      wok1_r  <= wok1_nxt;
      widx1_r <= in_tdata[TAW-1:0];
      wh1_r   <= in_tdata[38:15];
      sx1_r   <= cx_nxt[CW-1:FW];
      sz1_r   <= cz_nxt[CW-1:FW];
      rx1_r   <= cx_nxt[FW-1:0];
      rz1_r   <= cz_nxt[FW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: base vertex address and triangle choice.
  logic [AW-1:0]    stride;
  logic [AW-1:0]    hs_nxt;
  logic [COEFW-1:0] fsum;
  logic             lower_nxt;

  logic             q2_r, wok2_r, lower2_r;
  logic [TAW-1:0]   widx2_r;
  logic [H_W-1:0]   wh2_r;
  logic [AW-1:0]    hs2_r;
  logic [FW-1:0]    rx2_r, rz2_r;

  assign stride    = AW'(map_width_r) + AW'(1);
  assign hs_nxt    = AW'(sx1_r) + AW'(sz1_r) * stride;
  assign fsum      = COEFW'(rx1_r) + COEFW'(rz1_r);
  assign lower_nxt = (fsum < COEFW'(htss_pkg::CELL_SIZE));

  always_ff @(posedge clk) begin
    if (en2) begin
      q2_r     <= q1_r;
      wok2_r   <= wok1_r;
      widx2_r  <= widx1_r;
      wh2_r    <= wh1_r;
      hs2_r    <= hs_nxt;
      rx2_r    <= rx1_r;
      rz2_r    <= rz1_r;
      lower2_r <= lower_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: the four corner addresses and their range flags.
  logic [3:0][AW-1:0] corner;
  logic [3:0]         cok_nxt;

  logic               q3_r, wok3_r, lower3_r;
  logic [TAW-1:0]     widx3_r;
  logic [H_W-1:0]     wh3_r;
  logic [3:0][TAW-1:0] addr3_r;
  logic [3:0]         cok3_r;
  logic [FW-1:0]      rx3_r, rz3_r;

  // Corner order: near-left, near-right, far-left, far-right.
  always_comb begin
    corner[0] = hs2_r;
    corner[1] = hs2_r + AW'(1);
    corner[2] = hs2_r + stride;
    corner[3] = hs2_r + stride + AW'(1);
    for (int i = 0; i < 4; i++) begin
      cok_nxt[i] = (corner[i] < AW'(htss_pkg::TABLE_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      q3_r     <= q2_r;
      wok3_r   <= wok2_r;
      widx3_r  <= widx2_r;
      wh3_r    <= wh2_r;
      for (int i = 0; i < 4; i++) begin
        addr3_r[i] <= corner[i][TAW-1:0];
      end
      cok3_r   <= cok_nxt;
      rx3_r    <= rx2_r;
      rz3_r    <= rz2_r;
      lower3_r <= lower2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: table access. Writes and reads meet here in request order.
  htss_pkg::tbl_req_t          tbl_req;
  logic [3:0][H_W-1:0]         tbl_rd;

  logic [3:0]                  cok4_r;
  logic                        lower4_r;
  logic [FW-1:0]               rx4_r, rz4_r;

  always_comb begin
    tbl_req.rd_en   = en4;
    tbl_req.wr_en   = en4 && v3_r && !q3_r && wok3_r;
    tbl_req.wr_addr = widx3_r;
    tbl_req.wr_data = wh3_r;
    tbl_req.rd_addr = addr3_r;
  end

  htss_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (tbl_rd)
  );

  always_ff @(posedge clk) begin
    if (en4) begin
      cok4_r   <= cok3_r;
      lower4_r <= lower3_r;
      rx4_r    <= rx3_r;
      rz4_r    <= rz3_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: pick the triangle's base, edge differences and weights.
  logic signed [H_W-1:0] h00, h10, h01, h11;
  logic signed [H_W-1:0] base_nxt;
  logic signed [DW-1:0]  da_nxt, db_nxt;
  logic [COEFW-1:0]      ca_nxt, cb_nxt;

  logic signed [H_W-1:0] base5_r;
  logic signed [DW-1:0]  da5_r, db5_r;
  logic [COEFW-1:0]      ca5_r, cb5_r;

  // A corner beyond the table reads as zero height.
  assign h00 = cok4_r[0] ? $signed(tbl_rd[0]) : '0;
  assign h10 = cok4_r[1] ? $signed(tbl_rd[1]) : '0;
  assign h01 = cok4_r[2] ? $signed(tbl_rd[2]) : '0;
  assign h11 = cok4_r[3] ? $signed(tbl_rd[3]) : '0;

  always_comb begin
    if (lower4_r) begin
      base_nxt = h00;
      da_nxt   = DW'(h10) - DW'(h00);
      db_nxt   = DW'(h01) - DW'(h00);
      ca_nxt   = COEFW'(rx4_r);
      cb_nxt   = COEFW'(rz4_r);
    end else begin
      base_nxt = h11;
      da_nxt   = DW'(h01) - DW'(h11);
      db_nxt   = DW'(h10) - DW'(h11);
      ca_nxt   = COEFW'(htss_pkg::CELL_SIZE) - COEFW'(rx4_r);
      cb_nxt   = COEFW'(htss_pkg::CELL_SIZE) - COEFW'(rz4_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      base5_r <= base_nxt;
      da5_r   <= da_nxt;
      db5_r   <= db_nxt;
      ca5_r   <= ca_nxt;
      cb5_r   <= cb_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: the two weighted edge products.
  logic signed [PW-1:0]  pa_nxt, pb_nxt;
  logic signed [PW-1:0]  pa6_r, pb6_r;
  logic signed [H_W-1:0] base6_r;

  assign pa_nxt = $signed({1'b0, ca5_r}) * da5_r;
  assign pb_nxt = $signed({1'b0, cb5_r}) * db5_r;

  always_ff @(posedge clk) begin
    if (en6) begin
      pa6_r   <= pa_nxt;
      pb6_r   <= pb_nxt;
      base6_r <= base5_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: sum and divide by the square size, rounding toward minus infinity.
  logic signed [SW-1:0]  sum_nxt;
  logic signed [QW-1:0]  q7_r;
  logic signed [H_W-1:0] base7_r;

  assign sum_nxt = {pa6_r[PW-1], pa6_r} + {pb6_r[PW-1], pb6_r};

  always_ff @(posedge clk) begin
    if (en7) begin
      q7_r    <= $signed(sum_nxt[SW-1:FW]);
      base7_r <= base6_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 8: add the base height and saturate into the output register.
  localparam int HW_EXT = QW + 1;
  localparam int OUT_W_LOCAL = htss_pkg::OUT_W;

  logic signed [HW_EXT-1:0] hsum;
  logic [OUT_W_LOCAL-1:0]   hsat_nxt;
  logic [htss_pkg::OUT_W-1:0] out_data_r;

  assign hsum = {{(HW_EXT-H_W){base7_r[H_W-1]}}, base7_r} + {q7_r[QW-1], q7_r};

  always_comb begin
    if (hsum[HW_EXT-1:H_W-1] != {(HW_EXT-H_W+1){hsum[H_W-1]}}) begin
      hsat_nxt = hsum[HW_EXT-1] ? {1'b1, {(H_W-1){1'b0}}} : {1'b0, {(H_W-1){1'b1}}};
    end else begin
      hsat_nxt = hsum[H_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en8) begin
      out_data_r <= hsat_nxt;
    end
  end

  assign out_tdata = out_data_r;

  // ---------------------------------------------------------------------
  // Valid bits. Write requests leave the pipeline at the table stage.
  logic v4_nxt;

  assign v4_nxt = v3_r && q3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r        <= in_tvalid;
      if (en2) v2_r        <= v1_r;
      if (en3) v3_r        <= v2_r;
      if (en4) v4_r        <= v4_nxt;
      if (en5) v5_r        <= v4_r;
      if (en6) v6_r        <= v5_r;
      if (en7) v7_r        <= v6_r;
      if (en8) out_valid_r <= v7_r;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  `HTSS_ASSERT_NOW(a_full_when_blocked, clk, rst_n, !in_tready, v1_r && v2_r && v3_r && v4_r && v5_r && v6_r && v7_r && out_valid_r && !out_tready, "input blocked while a stage is empty")
  `HTSS_ASSERT_NEXT(a_held_stage_kept, clk, rst_n, v7_r && !en8, v7_r, "held stage lost its word")
  `HTSS_ASSERT_NEXT(a_write_no_result, clk, rst_n, tbl_req.wr_en, !v4_r, "table write produced a result word")

endmodule

`default_nettype wire
